### src/sbc_pkg.sv
// shared constants and codes for the segment box crop block
// no dependencies
package sbc_pkg;

   localparam int FIELD_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_SIDES = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BOX_LEFT   = 2'd0,
      CSR_BOX_RIGHT  = 2'd1,
      CSR_BOX_BOTTOM = 2'd2,
      CSR_BOX_TOP    = 2'd3
   } csr_index_type;

   // box sides; bit 0 gives the axis (0: line x = c, 1: line y = c)
   localparam int SIDE_LEFT   = 0;
   localparam int SIDE_BOTTOM = 1;
   localparam int SIDE_RIGHT  = 2;
   localparam int SIDE_TOP    = 3;

endpackage

### src/segment_box_crop.sv
// top level of the segment box crop block: box registers, setup, lanes, select
// depends on sbc_pkg and sbc_interp
//
//  port group  direction  handshake                 payload
//  req_*       in         start & !busy             first/second x, y, z
//  rsp_*       out        rsp_strobe, one cycle     visible, cropped endpoints
//  csr_*       in         csr_write                 csr_index, csr_wdata
//
// one transaction per cycle; each passes from accept to rsp_strobe through the
// bit-per-stage dividers in the eight interpolation lanes.
// busy is always low: the pipeline never stalls and the receiver cannot stall it.
// synchronous reset clears the valid bits and the box registers to zero.
module segment_box_crop #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_first_x,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_first_y,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_first_z,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_second_x,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_second_y,
   input  logic signed [sbc_pkg::FIELD_W-1:0]  req_second_z,
   output logic                                rsp_strobe,
   output logic                                rsp_visible,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_first_out_x,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_first_out_y,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_first_out_z,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_second_out_x,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_second_out_y,
   output logic signed [sbc_pkg::FIELD_W-1:0]  rsp_second_out_z,
   input  logic                                csr_write,
   input  logic        [sbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [sbc_pkg::FIELD_W-1:0]  csr_wdata
);
   import sbc_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int LAT   = W + 2;
   localparam int LANES = 2 * NUM_SIDES;

   typedef logic signed [W-1:0] coord_type;

   typedef struct packed {
      coord_type             ax, ay, az, bx, by, bz;
      logic [NUM_SIDES-1:0]  crossed;
      logic [NUM_SIDES-1:0]  deg;
   } band_type;

   // box registers
   coord_type box_ff [NUM_SIDES];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_SIDES; s++) begin
            box_ff[s] <= '0;
         end
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_BOX_LEFT:   box_ff[SIDE_LEFT]   <= csr_wdata[W-1:0];
            CSR_BOX_RIGHT:  box_ff[SIDE_RIGHT]  <= csr_wdata[W-1:0];
            CSR_BOX_BOTTOM: box_ff[SIDE_BOTTOM] <= csr_wdata[W-1:0];
            CSR_BOX_TOP:    box_ff[SIDE_TOP]    <= csr_wdata[W-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 0: input capture
   logic      v0_ff;
   coord_type a0x_ff, a0y_ff, a0z_ff, b0x_ff, b0y_ff, b0z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else begin
         v0_ff <= start & ~busy;
      end
      a0x_ff <= req_first_x[W-1:0];
      a0y_ff <= req_first_y[W-1:0];
      a0z_ff <= req_first_z[W-1:0];
      b0x_ff <= req_second_x[W-1:0];
      b0y_ff <= req_second_y[W-1:0];
      b0z_ff <= req_second_z[W-1:0];
   end

   // stage 1: crossing tests, distances and lane operands
   logic         v1_ff;
   band_type     band1_ff, band1_in;
   logic [W-1:0] num1_ff [NUM_SIDES];
   logic [W-1:0] den1_ff [NUM_SIDES];
   logic [W-1:0] mag1_ff [LANES];
   logic         neg1_ff [LANES];
   logic [W-1:0] num1_in [NUM_SIDES];
   logic [W-1:0] den1_in [NUM_SIDES];
   logic [W-1:0] mag1_in [LANES];
   logic         neg1_in [LANES];

   always_comb begin
      logic signed [W:0] pa, pb, cc, nv, dv, p0, p1, df;
      band1_in.ax = a0x_ff;
      band1_in.ay = a0y_ff;
      band1_in.az = a0z_ff;
      band1_in.bx = b0x_ff;
      band1_in.by = b0y_ff;
      band1_in.bz = b0z_ff;
      for (int s = 0; s < NUM_SIDES; s++) begin
         pa = (s % 2 == 1) ? (W+1)'(a0y_ff) : (W+1)'(a0x_ff);
         pb = (s % 2 == 1) ? (W+1)'(b0y_ff) : (W+1)'(b0x_ff);
         cc = (W+1)'(box_ff[s]);
         band1_in.crossed[s] = !((pa < cc) && (pb < cc)) && !((pa > cc) && (pb > cc));
         nv = pa - cc;
         dv = pa - pb;
         band1_in.deg[s] = (dv == '0);
         num1_in[s] = nv[W] ? W'(-nv) : nv[W-1:0];
         den1_in[s] = dv[W] ? W'(-dv) : dv[W-1:0];
         for (int j = 0; j < 2; j++) begin
            if (j == 1) begin
               p0 = (W+1)'(a0z_ff);
               p1 = (W+1)'(b0z_ff);
            end else if (s % 2 == 1) begin
               p0 = (W+1)'(a0x_ff);
               p1 = (W+1)'(b0x_ff);
            end else begin
               p0 = (W+1)'(a0y_ff);
               p1 = (W+1)'(b0y_ff);
            end
            df = p1 - p0;
            neg1_in[2*s+j] = df[W];
            mag1_in[2*s+j] = df[W] ? W'(-df) : df[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v0_ff;
      end
      band1_ff <= band1_in;
      num1_ff  <= num1_in;
      den1_ff  <= den1_in;
      mag1_ff  <= mag1_in;
      neg1_ff  <= neg1_in;
   end

   // interpolation lanes: side s, lane 2s is the other planar axis, 2s+1 is z
   coord_type lane_res [LANES];

   for (genvar k = 0; k < LANES; k++) begin : g_lane
      coord_type p0;
      if (k % 2 == 1) begin : g_z
         assign p0 = band1_ff.az;
      end else if ((k / 2) % 2 == 1) begin : g_x
         assign p0 = band1_ff.ax;
      end else begin : g_y
         assign p0 = band1_ff.ay;
      end
      sbc_interp #(.W(W)) u_interp (
         .clock  (clock),
         .p0     (p0),
         .mag    (mag1_ff[k]),
         .num    (num1_ff[k/2]),
         .den    (den1_ff[k/2]),
         .neg    (neg1_ff[k]),
         .result (lane_res[k])
      );
   end

   // side band delay line matching the lane latency
   logic     vd_ff    [LAT];
   band_type band_d_ff [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            vd_ff[i] <= 1'b0;
         end
      end else begin
         vd_ff[0] <= v1_ff;
         for (int i = 1; i < LAT; i++) begin
            vd_ff[i] <= vd_ff[i-1];
         end
      end
      band_d_ff[0] <= band1_ff;
      for (int i = 1; i < LAT; i++) begin
         band_d_ff[i] <= band_d_ff[i-1];
      end
   end

   // stage 2: crossing points and box tests
   band_type             bd;
   logic                 v2_ff;
   logic                 ina2_ff, inb2_ff, ina2_in, inb2_in;
   logic [NUM_SIDES-1:0] hit2_ff, hit2_in;
   coord_type            ax2_ff, ay2_ff, az2_ff, bx2_ff, by2_ff, bz2_ff;
   coord_type            px2_ff [NUM_SIDES], py2_ff [NUM_SIDES], pz2_ff [NUM_SIDES];
   coord_type            px2_in [NUM_SIDES], py2_in [NUM_SIDES], pz2_in [NUM_SIDES];

   assign bd = band_d_ff[LAT-1];

   always_comb begin
      ina2_in = (bd.ax >= box_ff[SIDE_LEFT]) && (bd.ax <= box_ff[SIDE_RIGHT]) &&
                (bd.ay >= box_ff[SIDE_BOTTOM]) && (bd.ay <= box_ff[SIDE_TOP]);
      inb2_in = (bd.bx >= box_ff[SIDE_LEFT]) && (bd.bx <= box_ff[SIDE_RIGHT]) &&
                (bd.by >= box_ff[SIDE_BOTTOM]) && (bd.by <= box_ff[SIDE_TOP]);
      for (int s = 0; s < NUM_SIDES; s++) begin
         // a segment lying on the line takes the start point
         pz2_in[s] = bd.deg[s] ? bd.az : lane_res[2*s+1];
         if (s % 2 == 1) begin
            px2_in[s] = bd.deg[s] ? bd.ax : lane_res[2*s];
            py2_in[s] = box_ff[s];
         end else begin
            px2_in[s] = box_ff[s];
            py2_in[s] = bd.deg[s] ? bd.ay : lane_res[2*s];
         end
         hit2_in[s] = bd.crossed[s] &&
                      (px2_in[s] >= box_ff[SIDE_LEFT]) && (px2_in[s] <= box_ff[SIDE_RIGHT]) &&
                      (py2_in[s] >= box_ff[SIDE_BOTTOM]) && (py2_in[s] <= box_ff[SIDE_TOP]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= vd_ff[LAT-1];
      end
      ina2_ff <= ina2_in;
      inb2_ff <= inb2_in;
      hit2_ff <= hit2_in;
      px2_ff  <= px2_in;
      py2_ff  <= py2_in;
      pz2_ff  <= pz2_in;
      ax2_ff  <= bd.ax;
      ay2_ff  <= bd.ay;
      az2_ff  <= bd.az;
      bx2_ff  <= bd.bx;
      by2_ff  <= bd.by;
      bz2_ff  <= bd.bz;
   end

   // stage 3: search order selection and result register
   logic      strobe_ff;
   logic      vis_ff, vis_in;
   coord_type oax_ff, oay_ff, oaz_ff, obx_ff, oby_ff, obz_ff;
   coord_type oax_in, oay_in, oaz_in, obx_in, oby_in, obz_in;

   always_comb begin
      logic      fwd_ok, back_ok;
      coord_type fx, fy, fz, kx, ky, kz;
      fwd_ok = 1'b0;
      fx = px2_ff[SIDE_LEFT];
      fy = py2_ff[SIDE_LEFT];
      fz = pz2_ff[SIDE_LEFT];
      priority if (hit2_ff[SIDE_LEFT]) begin
         fwd_ok = 1'b1;
      end else if (hit2_ff[SIDE_BOTTOM]) begin
         fwd_ok = 1'b1;
         fx = px2_ff[SIDE_BOTTOM];
         fy = py2_ff[SIDE_BOTTOM];
         fz = pz2_ff[SIDE_BOTTOM];
      end else if (hit2_ff[SIDE_RIGHT]) begin
         fwd_ok = 1'b1;
         fx = px2_ff[SIDE_RIGHT];
         fy = py2_ff[SIDE_RIGHT];
         fz = pz2_ff[SIDE_RIGHT];
      end else if (hit2_ff[SIDE_TOP]) begin
         fwd_ok = 1'b1;
         fx = px2_ff[SIDE_TOP];
         fy = py2_ff[SIDE_TOP];
         fz = pz2_ff[SIDE_TOP];
      end else begin
         fwd_ok = 1'b0;
      end
      back_ok = 1'b0;
      kx = px2_ff[SIDE_TOP];
      ky = py2_ff[SIDE_TOP];
      kz = pz2_ff[SIDE_TOP];
      priority if (hit2_ff[SIDE_TOP]) begin
         back_ok = 1'b1;
      end else if (hit2_ff[SIDE_RIGHT]) begin
         back_ok = 1'b1;
         kx = px2_ff[SIDE_RIGHT];
         ky = py2_ff[SIDE_RIGHT];
         kz = pz2_ff[SIDE_RIGHT];
      end else if (hit2_ff[SIDE_BOTTOM]) begin
         back_ok = 1'b1;
         kx = px2_ff[SIDE_BOTTOM];
         ky = py2_ff[SIDE_BOTTOM];
         kz = pz2_ff[SIDE_BOTTOM];
      end else if (hit2_ff[SIDE_LEFT]) begin
         back_ok = 1'b1;
         kx = px2_ff[SIDE_LEFT];
         ky = py2_ff[SIDE_LEFT];
         kz = pz2_ff[SIDE_LEFT];
      end else begin
         back_ok = 1'b0;
      end

      oax_in = ax2_ff;
      oay_in = ay2_ff;
      oaz_in = az2_ff;
      obx_in = bx2_ff;
      oby_in = by2_ff;
      obz_in = bz2_ff;
      priority if (ina2_ff && inb2_ff) begin
         vis_in = 1'b1;
      end else if (ina2_ff) begin
         // start kept, end takes the forward search
         vis_in = fwd_ok;
         obx_in = fx;
         oby_in = fy;
         obz_in = fz;
      end else if (inb2_ff) begin
         vis_in = fwd_ok;
         oax_in = fx;
         oay_in = fy;
         oaz_in = fz;
      end else begin
         vis_in = fwd_ok && back_ok;
         oax_in = fx;
         oay_in = fy;
         oaz_in = fz;
         obx_in = kx;
         oby_in = ky;
         obz_in = kz;
      end
      if (!vis_in) begin
         oax_in = '0;
         oay_in = '0;
         oaz_in = '0;
         obx_in = '0;
         oby_in = '0;
         obz_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v2_ff;
      end
      vis_ff <= vis_in;
      oax_ff <= oax_in;
      oay_ff <= oay_in;
      oaz_ff <= oaz_in;
      obx_ff <= obx_in;
      oby_ff <= oby_in;
      obz_ff <= obz_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_visible      = vis_ff;
   assign rsp_first_out_x  = FIELD_W'(oax_ff);
   assign rsp_first_out_y  = FIELD_W'(oay_ff);
   assign rsp_first_out_z  = FIELD_W'(oaz_ff);
   assign rsp_second_out_x = FIELD_W'(obx_ff);
   assign rsp_second_out_y = FIELD_W'(oby_ff);
   assign rsp_second_out_z = FIELD_W'(obz_ff);

endmodule

### src/sbc_interp.sv
// one interpolation lane: p0 +/- round(mag * n / d), half away from zero
// multiplier stage, one restoring division bit per stage, rounding stage; no package use
module sbc_interp #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic signed [W-1:0] p0,
   input  logic        [W-1:0] mag,
   input  logic        [W-1:0] num,
   input  logic        [W-1:0] den,
   input  logic                neg,
   output logic signed [W-1:0] result
);

   logic        [W-1:0] rem_ff  [0:W];
   logic        [W-1:0] low_ff  [0:W];
   logic        [W-1:0] quo_ff  [0:W];
   logic        [W-1:0] den_ff  [0:W];
   logic signed [W-1:0] p0_ff   [0:W];
   logic                neg_ff  [0:W];
   logic signed [W-1:0] result_ff;
   logic signed [W-1:0] result_in;
   logic      [2*W-1:0] prod;

   // quotient stays below 2^W when num <= den, as on a crossed side, since the high half is then below den
   assign prod = mag * num;

   always_ff @(posedge clock) begin
      rem_ff[0] <= prod[2*W-1:W];
      low_ff[0] <= prod[W-1:0];
      quo_ff[0] <= '0;
      den_ff[0] <= den;
      p0_ff[0]  <= p0;
      neg_ff[0] <= neg;
   end

   for (genvar i = 0; i < W; i++) begin : g_div
      logic [W:0] trial;
      logic       take;
      assign trial = {rem_ff[i], low_ff[i][W-1]};
      assign take  = trial >= {1'b0, den_ff[i]};
      always_ff @(posedge clock) begin
         rem_ff[i+1] <= take ? W'(trial - {1'b0, den_ff[i]}) : trial[W-1:0];
         low_ff[i+1] <= {low_ff[i][W-2:0], 1'b0};
         quo_ff[i+1] <= {quo_ff[i][W-2:0], take};
         den_ff[i+1] <= den_ff[i];
         p0_ff[i+1]  <= p0_ff[i];
         neg_ff[i+1] <= neg_ff[i];
      end
   end

   always_comb begin
      logic [W-1:0] q;
      q = quo_ff[W];
      if ({rem_ff[W], 1'b0} >= {1'b0, den_ff[W]}) begin
         q = q + W'(1);
      end
      result_in = neg_ff[W] ? p0_ff[W] - $signed(q) : p0_ff[W] + $signed(q);
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
